// File: rtl/core/csl_pkg.sv
// Shared types, constants and character classes for the character stream lexer.
package csl_pkg;

    localparam int ValueWidth = 32;
    localparam int QueueDepth = 2;

    typedef enum logic [11:0] {
        M_UNPRIMED = 12'b000000000001,
        M_NORMAL   = 12'b000000000010,
        M_IDENT    = 12'b000000000100,
        M_INT      = 12'b000000001000,
        M_FRAC     = 12'b000000010000,
        M_EXPSIGN  = 12'b000000100000,
        M_EXP      = 12'b000001000000,
        M_BLOCK    = 12'b000010000000,
        M_BLOCKEND = 12'b000100000000,
        M_LINE     = 12'b001000000000,
        M_SKIP     = 12'b010000000000,
        M_END      = 12'b100000000000
    } mode_t;

    localparam logic [4:0] T_NONE  = 5'd0;
    localparam logic [4:0] T_END   = 5'd1;
    localparam logic [4:0] T_IDENT = 5'd2;
    localparam logic [4:0] T_INT   = 5'd3;
    localparam logic [4:0] T_FLOAT = 5'd4;
    localparam logic [4:0] T_ERROR = 5'd5;
    localparam logic [4:0] T_KW0   = 5'd6;
    localparam logic [4:0] T_SYM0  = 5'd12;
    localparam logic [4:0] T_LE    = 5'd29;
    localparam logic [4:0] T_GE    = 5'd30;
    localparam logic [4:0] T_EQEQ  = 5'd31;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_CHAR  = 2'd1;
    localparam logic [1:0] E_SIGN  = 2'd2;
    localparam logic [1:0] E_EXPCH = 2'd3;

    // character classes computed in the front part, carried with the beat
    typedef struct packed {
        logic [7:0] c;
        logic       digit;
        logic       letter;
        logic       space;
        logic       expm;
        logic [4:0] sym;   // symbol token, T_NONE when not a symbol
    } cls_t;

    typedef struct packed {
        logic       prime;
        cls_t       cur;
        cls_t       look;
    } qent_t;

    typedef struct packed {
        logic [4:0]            kind;
        logic [ValueWidth-1:0] value;
        logic [1:0]            err;
    } tok_t;

    function automatic logic [4:0] sym_code(input logic [7:0] c);
        logic [4:0] r;
        r = T_NONE;
        case (c)
            8'h2A: r = 5'd12;
            8'h2C: r = 5'd13;
            8'h2D: r = 5'd14;
            8'h2B: r = 5'd15;
            8'h2F: r = 5'd16;
            8'h5B: r = 5'd17;
            8'h5D: r = 5'd18;
            8'h7B: r = 5'd19;
            8'h7D: r = 5'd20;
            8'h28: r = 5'd21;
            8'h29: r = 5'd22;
            8'h3D: r = 5'd23;
            8'h3C: r = 5'd24;
            8'h3E: r = 5'd25;
            8'h5E: r = 5'd26;
            8'h3F: r = 5'd27;
            8'h21: r = 5'd28;
            default: r = T_NONE;
        endcase
        return r;
    endfunction

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r.c      = c;
        r.digit  = (c >= 8'h30) && (c <= 8'h39);
        r.letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                   || (c == 8'h5F);
        r.space  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
        r.expm   = (c == 8'h65) || (c == 8'h45);
        r.sym    = sym_code(c);
        return r;
    endfunction

endpackage

// File: rtl/core/csl_front.sv
// Front part: holds the lookahead, classifies characters and forms scan beats.
module csl_front
    import csl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid,
    output logic  stall,
    input  logic  [7:0] ch,
    output logic  q_valid,
    input  logic  q_stall,
    output qent_t q_data
);

    logic  primed_reg, primed_next;
    cls_t  look_reg, look_next;
    logic  ovalid_reg, ovalid_next;
    qent_t odata_reg, odata_next;
    logic  take;

    assign stall = ovalid_reg && q_stall;
    assign take  = valid && !stall;

    always_comb
    begin
        primed_next = primed_reg;
        look_next   = look_reg;
        ovalid_next = ovalid_reg && q_stall;
        odata_next  = odata_reg;
        if (take)
        begin
            primed_next     = 1'b1;
            look_next       = classify(ch);
            ovalid_next     = 1'b1;
            odata_next.prime = !primed_reg;
            odata_next.cur   = look_reg;
            odata_next.look  = classify(ch);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            look_reg   <= classify(8'h00);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            primed_reg <= primed_next;
            look_reg   <= look_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign q_valid = ovalid_reg;
    assign q_data  = odata_reg;

endmodule

// File: rtl/core/csl_queue.sv
// Short queue between the front and back parts.
module csl_queue
    import csl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  qent_t in_data,
    output logic  out_valid,
    input  logic  out_stall,
    output qent_t out_data
);

    qent_t mem_reg [QueueDepth];
    logic  wp_reg, wp_next, rp_reg, rp_next;
    logic  [1:0] cnt_reg, cnt_next;
    logic  push, pop;

    assign in_stall  = (cnt_reg == 2'(QueueDepth));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

endmodule

// File: rtl/core/csl_back.sv
// Back part: scan mode machine, identifier buffer, keyword match, integer value.
module csl_back
    import csl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_stall,
    input  qent_t q_data,
    output logic  valid,
    input  logic  stall,
    output logic  [4:0] token_kind,
    output logic  [31:0] int_value,
    output logic  [1:0] error_kind
);

    localparam logic [ValueWidth-1:0] VMax = '1;
    localparam logic [ValueWidth-1:0] VDiv = VMax / 10;
    localparam logic [ValueWidth-1:0] VRem = VMax % 10;

    mode_t mode_reg, mode_next;
    logic  [7:0] buf_reg [6];
    logic  [7:0] buf_next [6];
    logic  [2:0] len_reg, len_next;
    logic  long_reg, long_next;
    logic  [ValueWidth-1:0] acc_reg, acc_next;
    logic  ovalid_reg, ovalid_next;
    tok_t  otok_reg, otok_next;
    logic  take;
    cls_t  cc, lc;
    tok_t  t;

    assign q_stall = ovalid_reg && stall;
    assign take    = q_valid && !q_stall;
    assign cc      = q_data.cur;
    assign lc      = q_data.look;

    function automatic logic [4:0] kw_match(input logic [7:0] b [6], input logic [2:0] n,
                                            input logic lng);
        logic [4:0] r;
        r = T_IDENT;
        if (!lng)
        begin
            if (n == 3'd4 && b[0] == "c" && b[1] == "a" && b[2] == "l" && b[3] == "l")
                r = T_KW0;
            else if (n == 3'd4 && b[0] == "i" && b[1] == "n" && b[2] == "i" && b[3] == "t")
                r = T_KW0 + 5'd1;
            else if (n == 3'd6 && b[0] == "u" && b[1] == "p" && b[2] == "d" && b[3] == "a"
                     && b[4] == "t" && b[5] == "e")
                r = T_KW0 + 5'd2;
            else if (n == 3'd4 && b[0] == "B" && b[1] == "O" && b[2] == "O" && b[3] == "L")
                r = T_KW0 + 5'd3;
            else if (n == 3'd5 && b[0] == "F" && b[1] == "L" && b[2] == "O" && b[3] == "A"
                     && b[4] == "T")
                r = T_KW0 + 5'd4;
            else if (n == 3'd3 && b[0] == "I" && b[1] == "N" && b[2] == "T")
                r = T_KW0 + 5'd5;
        end
        return r;
    endfunction

    always_comb
    begin
        logic       do_ident, do_int;
        logic [2:0] ilen;
        logic       ilong;
        logic [ValueWidth-1:0] base, dig;
        mode_next = mode_reg;
        buf_next  = buf_reg;
        len_next  = len_reg;
        long_next = long_reg;
        acc_next  = acc_reg;
        t.kind    = T_NONE;
        t.value   = '0;
        t.err     = E_NONE;
        do_ident  = 1'b0;
        do_int    = 1'b0;
        ilen      = len_reg;
        ilong     = long_reg;
        base      = acc_reg;
        dig       = '0;

        if (q_data.prime)
        begin
            mode_next = M_NORMAL;
        end
        else
        begin
            case (mode_reg)
                M_NORMAL:
                begin
                    if (cc.space)
                        t.kind = T_NONE;
                    else if (cc.letter)
                    begin
                        mode_next = M_IDENT;
                        ilen      = 3'd0;
                        ilong     = 1'b0;
                        do_ident  = 1'b1;
                    end
                    else if (cc.digit)
                    begin
                        mode_next = M_INT;
                        base      = '0;
                        do_int    = 1'b1;
                    end
                    else if (cc.c == "/" && lc.c == "/")
                        mode_next = M_LINE;
                    else if (cc.c == "/" && lc.c == "*")
                        mode_next = M_BLOCK;
                    else if (cc.c == 8'h00)
                    begin
                        mode_next = M_END;
                        t.kind    = T_END;
                    end
                    else if (lc.c == "=" && cc.c == "<")
                    begin
                        mode_next = M_SKIP;
                        t.kind    = T_LE;
                    end
                    else if (lc.c == "=" && cc.c == ">")
                    begin
                        mode_next = M_SKIP;
                        t.kind    = T_GE;
                    end
                    else if (lc.c == "=" && cc.c == "=")
                    begin
                        mode_next = M_SKIP;
                        t.kind    = T_EQEQ;
                    end
                    else if (cc.sym != T_NONE)
                        t.kind = cc.sym;
                    else
                    begin
                        t.kind = T_ERROR;
                        t.err  = E_CHAR;
                    end
                end
                M_IDENT: do_ident = 1'b1;
                M_INT:   do_int   = 1'b1;
                M_FRAC:
                begin
                    if (cc.expm)
                        mode_next = M_EXPSIGN;
                    else if (!(lc.digit || lc.expm))
                    begin
                        mode_next = M_NORMAL;
                        t.kind    = T_FLOAT;
                    end
                end
                M_EXPSIGN:
                begin
                    if (cc.c == "-" || cc.c == "+")
                    begin
                        if (!lc.digit)
                        begin
                            mode_next = M_NORMAL;
                            t.kind    = T_ERROR;
                            t.err     = E_SIGN;
                        end
                        else
                            mode_next = M_EXP;
                    end
                    else if (cc.digit)
                        mode_next = M_EXP;
                    else
                    begin
                        mode_next = M_NORMAL;
                        t.kind    = T_ERROR;
                        t.err     = E_EXPCH;
                    end
                end
                M_EXP:
                begin
                    if (!lc.digit)
                    begin
                        mode_next = M_NORMAL;
                        t.kind    = T_FLOAT;
                    end
                end
                M_BLOCK:
                begin
                    if (cc.c == "*" && lc.c == "/")
                        mode_next = M_BLOCKEND;
                    else if (lc.c == 8'h00)
                        mode_next = M_NORMAL;
                end
                M_LINE:
                begin
                    if (lc.c == 8'h00 || cc.c == 8'h0A)
                        mode_next = M_NORMAL;
                end
                M_BLOCKEND, M_SKIP: mode_next = M_NORMAL;
                default:
                begin
                    mode_next = M_END;
                    t.kind    = T_END;
                end
            endcase
        end

        if (do_ident)
        begin
            if (ilen != 3'd6)
            begin
                buf_next[ilen] = cc.c;
                ilen = ilen + 3'd1;
            end
            else
                ilong = 1'b1;
            len_next  = ilen;
            long_next = ilong;
            if (!lc.digit && !lc.letter)
            begin
                mode_next = M_NORMAL;
                t.kind    = kw_match(buf_next, ilen, ilong);
            end
        end

        if (do_int)
        begin
            dig = ValueWidth'(cc.c - 8'h30);
            acc_next = base;
            if (cc.digit)
            begin
                // saturate when base*10+dig would overflow
                if (base > VDiv || (base == VDiv && dig > VRem))
                    acc_next = VMax;
                else
                    acc_next = ValueWidth'(base * 10) + dig;
            end
            if (cc.c == ".")
                mode_next = M_FRAC;
            else if (cc.expm)
                mode_next = M_EXPSIGN;
            else if (!(lc.digit || lc.c == "." || lc.expm))
            begin
                mode_next = M_NORMAL;
                t.kind    = T_INT;
                t.value   = acc_next;
            end
        end

        ovalid_next = ovalid_reg && stall;
        otok_next   = otok_reg;
        if (take)
        begin
            ovalid_next = 1'b1;
            otok_next   = t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_UNPRIMED;
            len_reg    <= 3'd0;
            long_reg   <= 1'b0;
            acc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (take)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                long_reg <= long_next;
                acc_reg  <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        otok_reg <= otok_next;
        if (take)
        begin
            buf_reg <= buf_next;
        end
    end

    assign valid      = ovalid_reg;
    assign token_kind = otok_reg.kind;
    assign int_value  = otok_reg.value;
    assign error_kind = otok_reg.err;

endmodule

// File: rtl/core/char_stream_lexer.sv
// Top level of the character stream lexer.
// Usage:
//   Input channel (valid, stall, ch) carries one character byte a beat;
//   byte 0 marks end of text. Output channel (out_valid, out_stall,
//   token_kind, int_value, error_kind) carries exactly one beat per input
//   beat; token_kind 0 means no token at that position.
//   The first beat after reset only primes the lookahead and yields a
//   beat with token 0.
//   Throughput: one byte per cycle while out_stall stays low, set by the mode
//   update in the back part. Each input beat passes through the front
//   register, the queue and the back output register to the output.
//   Reset clears mode, lookahead, counters and both handshakes; the
//   identifier buffer is not cleared.
//   When the receiver stalls, the output beat holds; the two-entry queue
//   and the front register absorb beats, then stall rises on the input.
module char_stream_lexer
    import csl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [31:0] int_value,
    output logic [1:0]  error_kind
);

    logic  f_valid, f_stall, b_valid, b_stall;
    qent_t f_data, b_data;

    csl_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall), .ch(ch),
        .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
    );

    csl_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_stall(f_stall),
        .in_data(f_data), .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
    );

    csl_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
        .valid(out_valid), .stall(out_stall), .token_kind(token_kind),
        .int_value(int_value), .error_kind(error_kind)
    );

endmodule

// File: rtl/core/csl_checker.sv
// Port-level checker for the character stream lexer, bound to the top level.
module csl_checker
    import csl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  token_kind,
    input logic [31:0] int_value,
    input logic [1:0]  error_kind
);

    a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != T_INT |-> int_value == 32'd0)
        else $error("int_value set on non-integer token");

    a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == T_ERROR) == (error_kind != E_NONE)))
        else $error("error_kind does not match token");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind))
        else $error("stalled beat changed");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && token_kind == T_END ##1 out_valid |->
        token_kind == T_END)
        else $error("token after end");

    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !stall)
        else $error("input stalled with empty output");

endmodule

bind char_stream_lexer csl_checker u_csl_checker (
    .clk(clk), .rst_n(rst_n), .stall(stall), .out_valid(out_valid),
    .out_stall(out_stall), .token_kind(token_kind), .int_value(int_value),
    .error_kind(error_kind)
);
